// ===== rtl/c3s_pkg.sv =====
// ----------------------------------------------------------------------------
// c3s_pkg: shared types and constants of the 3x3 convolution filter
// Field widths, register reset values, register indexes and pipeline flags.
// ----------------------------------------------------------------------------
`default_nettype none

package c3s_pkg;

   localparam int unsigned MAX_WIDTH_DEFAULT = 2048;
   localparam int unsigned KERNEL_SIZE       = 3;

   localparam int unsigned PIX_W       = 8;
   localparam int unsigned KROW_W      = 24;
   localparam int unsigned GEOM_W      = 12;
   localparam int unsigned CSR_INDEX_W = 3;
   localparam int unsigned CSR_DATA_W  = 24;
   localparam int unsigned PROD_W      = 17;
   localparam int unsigned ACC_W       = 21;

   localparam logic [KROW_W-1:0] KERNEL_TOP_RESET = 24'hFEFEFE;
   localparam logic [KROW_W-1:0] KERNEL_MID_RESET = 24'hFE11FE;
   localparam logic [KROW_W-1:0] KERNEL_BOT_RESET = 24'hFEFEFE;
   localparam logic [GEOM_W-1:0] WIDTH_RESET      = 12'd640;
   localparam logic [GEOM_W-1:0] HEIGHT_RESET     = 12'd480;
   localparam logic [GEOM_W-1:0] GEOM_MIN         = 12'd5;
   localparam logic [GEOM_W-1:0] ROW_MAX          = 12'hFFF;
   localparam logic [PIX_W-1:0]  PIX_MAX          = 8'hFF;

   typedef enum logic [CSR_INDEX_W-1:0] {
      CSR_KERNEL_TOP = 3'd0,
      CSR_KERNEL_MID = 3'd1,
      CSR_KERNEL_BOT = 3'd2,
      CSR_WIDTH      = 3'd3,
      CSR_HEIGHT     = 3'd4
   } csr_index_type;

   // Per-item flags carried down the pipeline
   typedef struct packed {
      logic emit;      // item releases a result
      logic interior;  // result is the filtered sum
      logic edge_col;  // passthrough from the bottom-middle tap
      logic last;      // last result of the frame
   } c3s_ctl_type;

endpackage

`default_nettype wire

// ===== rtl/conv3x3_sharpen_filter.sv =====
// ----------------------------------------------------------------------------
// conv3x3_sharpen_filter: 3x3 signed-kernel filter on a raster pixel stream
// Line memory, 3x3 window, multiply stage and sum/saturate stage.
// ----------------------------------------------------------------------------
// Path: a result is registered through the read, window, product and output
//   stages after the input item that releases it (image_width+1 positions later).
// Throughput: one item per clock unless the result stream stalls; the line
//   memory has one read port, used at transfer, and one write port, used as stage 1 advances.
// Reset: synchronous, active high; clears counters, valid flags and the window
//   and loads the configuration reset values. Data pipeline registers are not cleared.
//   The line memory is not cleared; unwritten entries feed only borders.
`default_nettype none

module conv3x3_sharpen_filter #(
   parameter int unsigned MAX_WIDTH = c3s_pkg::MAX_WIDTH_DEFAULT
) (
   input  wire  logic                               clock,
   input  wire  logic                               reset,
   // input stream
   input  wire  logic                               req_tvalid,
   output logic                                     req_tready,
   input  wire  logic [c3s_pkg::PIX_W-1:0]          req_tdata,   // [7:0] pixel_in
   input  wire  logic                               req_tuser,   // [0] fill
   // result stream
   output logic                                     rsp_tvalid,
   input  wire  logic                               rsp_tready,
   output logic [c3s_pkg::PIX_W-1:0]                rsp_tdata,   // [7:0] pixel_out
   output logic                                     rsp_tlast,   // frame_last
   // register write channel
   input  wire  logic                               csr_valid,
   output logic                                     csr_ready,
   input  wire  logic [c3s_pkg::CSR_INDEX_W-1:0]    csr_index,
   input  wire  logic [c3s_pkg::CSR_DATA_W-1:0]     csr_data
);

   import c3s_pkg::*;

   localparam int unsigned COL_W = $clog2(MAX_WIDTH);  // column index bits
   localparam int unsigned WID_W = COL_W + 1;          // effective width bits
   localparam int unsigned CMP_W = WID_W + 1;          // column + 3 compare
   localparam int unsigned ROW_CMP_W = GEOM_W + 1;

   // ------------------------------------------------------------------
   // Configuration registers
   // ------------------------------------------------------------------
   logic [KROW_W-1:0] kernel_ff [KERNEL_SIZE];
   logic [GEOM_W-1:0] width_ff;
   logic [GEOM_W-1:0] height_ff;

   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         kernel_ff[0] <= KERNEL_TOP_RESET;
         kernel_ff[1] <= KERNEL_MID_RESET;
         kernel_ff[2] <= KERNEL_BOT_RESET;
         width_ff     <= WIDTH_RESET;
         height_ff    <= HEIGHT_RESET;
      end else if (csr_valid) begin
         case (csr_index_type'(csr_index))
            CSR_KERNEL_TOP: kernel_ff[0] <= csr_data;
            CSR_KERNEL_MID: kernel_ff[1] <= csr_data;
            CSR_KERNEL_BOT: kernel_ff[2] <= csr_data;
            CSR_WIDTH:      width_ff     <= csr_data[GEOM_W-1:0];
            CSR_HEIGHT:     height_ff    <= csr_data[GEOM_W-1:0];
            default:        ;  // drop writes past the register list
         endcase
      end
   end

   // Effective geometry: width clamped to 5..MAX_WIDTH, height to at least 5
   logic [WID_W-1:0]  w_eff;
   logic [WID_W-1:0]  w_last;
   logic [GEOM_W-1:0] h_eff;
   logic [GEOM_W-1:0] h_last;

   always_comb begin
      if (32'(width_ff) > MAX_WIDTH) begin
         w_eff = WID_W'(MAX_WIDTH);
      end else if (width_ff < GEOM_MIN) begin
         w_eff = WID_W'(GEOM_MIN);
      end else begin
         w_eff = WID_W'(width_ff);
      end
      h_eff  = (height_ff < GEOM_MIN) ? GEOM_MIN : height_ff;
      w_last = w_eff - WID_W'(1);
      h_last = h_eff - GEOM_W'(1);
   end

   // ------------------------------------------------------------------
   // Handshake: each stage advances when empty or when the next one moves,
   // so an empty slot upstream takes a new item even while a result waits.
   // ------------------------------------------------------------------
   logic        v1_ff, v2_ff, v3_ff, rsp_valid_ff;
   c3s_ctl_type ctl1_ff, ctl2_ff;
   logic        out_rdy, rdy3, rdy2, rdy1;
   logic        req_fire, s1_go;

   assign out_rdy  = !rsp_valid_ff || rsp_tready;
   assign rdy3     = !v3_ff || out_rdy;
   assign rdy2     = !v2_ff || !ctl2_ff.emit || rdy3;   // non-emitting items drop
   assign rdy1     = !v1_ff || rdy2;
   assign req_tready = rdy1;
   assign req_fire = req_tvalid && rdy1;
   assign s1_go    = v1_ff && rdy2;

   // ------------------------------------------------------------------
   // Position tracking and per-item decisions at transfer time
   // ------------------------------------------------------------------
   logic [COL_W-1:0]  in_col_ff,  in_col_in;
   logic [GEOM_W-1:0] in_row_ff,  in_row_in;
   logic [COL_W-1:0]  out_col_ff, out_col_in;
   logic [GEOM_W-1:0] out_row_ff, out_row_in;
   c3s_ctl_type       ctl0;
   logic              in_col_end;

   always_comb begin
      in_col_end    = WID_W'(in_col_ff) >= w_last;
      ctl0.emit     = (in_row_ff >= GEOM_W'(2))
                      || (in_row_ff == GEOM_W'(1) && in_col_ff != '0);
      ctl0.edge_col = WID_W'(out_col_ff) >= w_last;
      ctl0.last     = (out_row_ff >= h_last) && ctl0.edge_col;
      ctl0.interior = (out_row_ff >= GEOM_W'(2)) && (out_col_ff >= COL_W'(2))
                      && (ROW_CMP_W'(out_row_ff) + ROW_CMP_W'(3) <= ROW_CMP_W'(h_eff))
                      && (CMP_W'(out_col_ff) + CMP_W'(3) <= CMP_W'(w_eff));

      // input position: wrap at the row end, row saturates
      if (in_col_end) begin
         in_col_in = '0;
         in_row_in = (in_row_ff != ROW_MAX) ? in_row_ff + GEOM_W'(1) : in_row_ff;
      end else begin
         in_col_in = in_col_ff + COL_W'(1);
         in_row_in = in_row_ff;
      end

      // output position advances only on emitting items
      out_col_in = out_col_ff;
      out_row_in = out_row_ff;
      if (ctl0.emit) begin
         if (ctl0.edge_col) begin
            out_col_in = '0;
            out_row_in = out_row_ff + GEOM_W'(1);
         end else begin
            out_col_in = out_col_ff + COL_W'(1);
         end
      end

      // frame end restarts all positions
      if (ctl0.emit && ctl0.last) begin
         in_col_in  = '0;
         in_row_in  = '0;
         out_col_in = '0;
         out_row_in = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_col_ff  <= '0;
         in_row_ff  <= '0;
         out_col_ff <= '0;
         out_row_ff <= '0;
      end else if (req_fire) begin
         in_col_ff  <= in_col_in;
         in_row_ff  <= in_row_in;
         out_col_ff <= out_col_in;
         out_row_ff <= out_row_in;
      end
   end

   // ------------------------------------------------------------------
   // Stage 1: line memory read. Each word holds {older row, newer row}.
   // A column normally comes back at least five items later, so the
   // write-back, made as stage 1 advances, does not collide. The exception
   // is column 0 right after a frame end: that read misses the write-back
   // of the same edge and returns the previous pair, which reaches only
   // border taps of the first rows of the new frame.
   // ------------------------------------------------------------------
   logic [2*PIX_W-1:0] line_mem [MAX_WIDTH];
   logic [2*PIX_W-1:0] rd_ff;
   logic [PIX_W-1:0]   pix1_ff;
   logic [COL_W-1:0]   col1_ff;

   always_ff @(posedge clock) begin
      if (req_fire) begin
         rd_ff <= line_mem[in_col_ff];
      end
      if (s1_go) begin
         line_mem[col1_ff] <= {rd_ff[PIX_W-1:0], pix1_ff};  // shift column up
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
      end else if (rdy1) begin
         v1_ff <= req_tvalid;
      end
   end

   always_ff @(posedge clock) begin
      if (req_fire) begin
         pix1_ff <= req_tuser ? '0 : req_tdata;  // a fill item counts as zero
         col1_ff <= in_col_ff;
         ctl1_ff <= ctl0;
      end
   end

   // ------------------------------------------------------------------
   // Stage 2: 3x3 window, column 2 newest, row 2 the current line
   // ------------------------------------------------------------------
   logic [PIX_W-1:0] taps_ff [KERNEL_SIZE][KERNEL_SIZE];

   always_ff @(posedge clock) begin
      if (reset) begin
         v2_ff <= 1'b0;
      end else if (rdy2) begin
         v2_ff <= v1_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int r = 0; r < KERNEL_SIZE; r++) begin
            for (int k = 0; k < KERNEL_SIZE; k++) begin
               taps_ff[r][k] <= '0;
            end
         end
      end else if (s1_go) begin
         for (int r = 0; r < KERNEL_SIZE; r++) begin
            taps_ff[r][0] <= taps_ff[r][1];
            taps_ff[r][1] <= taps_ff[r][2];
         end
         taps_ff[0][2] <= rd_ff[2*PIX_W-1:PIX_W];
         taps_ff[1][2] <= rd_ff[PIX_W-1:0];
         taps_ff[2][2] <= pix1_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (s1_go) begin
         ctl2_ff <= ctl1_ff;
      end
   end

   // ------------------------------------------------------------------
   // Stage 3: nine coefficient x pixel products
   // ------------------------------------------------------------------
   logic signed [PROD_W-1:0] prod [KERNEL_SIZE][KERNEL_SIZE];
   logic signed [PROD_W-1:0] prod_ff [KERNEL_SIZE][KERNEL_SIZE];
   logic [PIX_W-1:0]         pass3_ff;
   logic                     interior3_ff;
   logic                     last3_ff;

   always_comb begin
      for (int r = 0; r < KERNEL_SIZE; r++) begin
         for (int k = 0; k < KERNEL_SIZE; k++) begin
            prod[r][k] = $signed(kernel_ff[r][PIX_W*k +: PIX_W])
                         * $signed({1'b0, taps_ff[r][k]});
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v3_ff <= 1'b0;
      end else if (rdy3) begin
         v3_ff <= v2_ff && ctl2_ff.emit;
      end
   end

   always_ff @(posedge clock) begin
      if (rdy3) begin
         prod_ff      <= prod;
         pass3_ff     <= ctl2_ff.edge_col ? taps_ff[2][1] : taps_ff[1][1];
         interior3_ff <= ctl2_ff.interior;
         last3_ff     <= ctl2_ff.last;
      end
   end

   // ------------------------------------------------------------------
   // Stage 4: sum, saturate to 0..255, output register
   // ------------------------------------------------------------------
   logic signed [ACC_W-1:0] acc;
   logic [PIX_W-1:0]        filt;
   logic [PIX_W-1:0]        rsp_data_ff;
   logic                    rsp_last_ff;

   always_comb begin
      acc = '0;
      for (int r = 0; r < KERNEL_SIZE; r++) begin
         for (int k = 0; k < KERNEL_SIZE; k++) begin
            acc = acc + ACC_W'(prod_ff[r][k]);
         end
      end
      if (acc < 0) begin
         filt = '0;
      end else if (acc > $signed(ACC_W'(PIX_MAX))) begin
         filt = PIX_MAX;
      end else begin
         filt = acc[PIX_W-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (out_rdy) begin
         rsp_valid_ff <= v3_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (out_rdy) begin
         rsp_data_ff <= interior3_ff ? filt : pass3_ff;
         rsp_last_ff <= last3_ff;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;
   assign rsp_tlast  = rsp_last_ff;

endmodule

`default_nettype wire

// ===== rtl/c3s_checker.sv =====
// ----------------------------------------------------------------------------
// c3s_checker: port-level checks of the 3x3 convolution filter
// Watches both streams; attached to the top level by the bind below.
// ----------------------------------------------------------------------------
`default_nettype none

module c3s_checker (
   input wire logic       clock,
   input wire logic       reset,
   input wire logic       req_tvalid,
   input wire logic       req_tready,
   input wire logic       rsp_tvalid,
   input wire logic       rsp_tready,
   input wire logic [7:0] rsp_tdata,
   input wire logic       rsp_tlast
);

   // Items taken in but not yet matched by a result; saturates and holds
   logic [15:0] pend_ff;
   logic        in_xfer, out_xfer;

   assign in_xfer  = req_tvalid && req_tready;
   assign out_xfer = rsp_tvalid && rsp_tready;

   always_ff @(posedge clock) begin
      if (reset) begin
         pend_ff <= '0;
      end else if (pend_ff != 16'hFFFF) begin
         pend_ff <= pend_ff + 16'(in_xfer) - 16'(out_xfer);
      end
   end

   a_reset_empty: assert property (@(posedge clock) reset |=> !rsp_tvalid)
      else $error("result valid right after reset");

   a_no_invented: assert property (@(posedge clock) disable iff (reset)
      out_xfer |-> (pend_ff != 16'd0 || in_xfer))
      else $error("result transfer without a pending input item");

   a_valid_holds: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid)
      else $error("result valid dropped while stalled");

   a_data_holds: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> $stable(rsp_tdata) && $stable(rsp_tlast))
      else $error("result payload changed while stalled");

endmodule

bind conv3x3_sharpen_filter c3s_checker u_c3s_checker (.*);

`default_nettype wire
